// ===== rtl/core/tcirc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcirc_pkg
// Widths, status codes and stage bundles shared by the circumcentre pipeline.
// ----------------------------------------------------------------------------
package tcirc_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;
    localparam int IN_W       = 6 * COORD_BITS;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DET_W  = PROD_W + 1;
    localparam int SQ_W   = PROD_W;
    localparam int LO_W   = 32;
    localparam int PL_W   = DIFF_W + LO_W + 1;
    localparam int PH_W   = DIFF_W + SQ_W - LO_W + 1;
    localparam int NUM_W  = DIFF_W + SQ_W + 1;
    localparam int ABS_W  = DET_W - 1;
    localparam int DEN_W  = DET_W;
    localparam int DIV_W  = NUM_W + FRAC_BITS + 2;
    localparam int CW     = DIV_W + 2;

    localparam int OUT_W  = 40;
    localparam int RSQ_W  = 64;
    localparam int ST_W   = 2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_DEGEN = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

    typedef struct packed {
        logic                          valid;
        logic signed [COORD_BITS-1:0]  ax;
        logic signed [COORD_BITS-1:0]  ay;
        logic                          degen;
        logic                          neg_x;
        logic                          neg_y;
        logic [DIV_W-1:0]              num_x;
        logic [DIV_W-1:0]              num_y;
        logic [DEN_W-1:0]              den;
    } t_front;

    typedef struct packed {
        logic                          valid;
        logic signed [COORD_BITS-1:0]  ax;
        logic signed [COORD_BITS-1:0]  ay;
        logic                          degen;
        logic                          neg_x;
        logic                          neg_y;
        logic [DEN_W-1:0]              den;
    } t_side;

    typedef struct packed {
        logic                          valid;
        logic signed [COORD_BITS-1:0]  ax;
        logic signed [COORD_BITS-1:0]  ay;
        logic                          degen;
        logic                          neg_x;
        logic                          neg_y;
        logic [DIV_W-1:0]              q_x;
        logic [DIV_W-1:0]              q_y;
    } t_quot;

endpackage
`default_nettype wire

// ===== rtl/core/tcirc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcirc_front
// Edge vectors, determinant, bisector numerators and divider operands.
// ----------------------------------------------------------------------------
module tcirc_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [tcirc_pkg::IN_W-1:0] i_data,
    output tcirc_pkg::t_front               o_front
);
    localparam int CB = tcirc_pkg::COORD_BITS;
    localparam int DW = tcirc_pkg::DIFF_W;
    localparam int PW = tcirc_pkg::PROD_W;
    localparam int TW = tcirc_pkg::DET_W;
    localparam int SW = tcirc_pkg::SQ_W;
    localparam int LW = tcirc_pkg::LO_W;
    localparam int PLW = tcirc_pkg::PL_W;
    localparam int PHW = tcirc_pkg::PH_W;
    localparam int NW = tcirc_pkg::NUM_W;
    localparam int AW = tcirc_pkg::ABS_W;
    localparam int VW = tcirc_pkg::DIV_W;
    localparam int EW = tcirc_pkg::DEN_W;

    logic signed [CB-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
    assign in_ax = i_data[0*CB +: CB];
    assign in_ay = i_data[1*CB +: CB];
    assign in_bx = i_data[2*CB +: CB];
    assign in_by = i_data[3*CB +: CB];
    assign in_cx = i_data[4*CB +: CB];
    assign in_cy = i_data[5*CB +: CB];

    // valid chain
    logic [6:0] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    // stage 1: edges relative to A
    logic signed [CB-1:0] r_ax1, r_ay1;
    logic signed [DW-1:0] r_a1, r_b1, r_d1, r_e1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax1 <= in_ax;
            r_ay1 <= in_ay;
            r_a1  <= DW'(in_bx) - DW'(in_ax);
            r_b1  <= DW'(in_by) - DW'(in_ay);
            r_d1  <= DW'(in_cx) - DW'(in_ax);
            r_e1  <= DW'(in_cy) - DW'(in_ay);
        end
    end

    // stage 2: products
    logic signed [CB-1:0] r_ax2, r_ay2;
    logic signed [DW-1:0] r_a2, r_b2, r_d2, r_e2;
    logic signed [PW-1:0] r_pae, r_pbd, r_paa, r_pbb, r_pdd, r_pee;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax2 <= r_ax1;
            r_ay2 <= r_ay1;
            r_a2  <= r_a1;
            r_b2  <= r_b1;
            r_d2  <= r_d1;
            r_e2  <= r_e1;
            r_pae <= PW'(r_a1) * PW'(r_e1);
            r_pbd <= PW'(r_b1) * PW'(r_d1);
            r_paa <= PW'(r_a1) * PW'(r_a1);
            r_pbb <= PW'(r_b1) * PW'(r_b1);
            r_pdd <= PW'(r_d1) * PW'(r_d1);
            r_pee <= PW'(r_e1) * PW'(r_e1);
        end
    end

    // stage 3: determinant and squared edge lengths
    logic signed [CB-1:0] r_ax3, r_ay3;
    logic signed [DW-1:0] r_a3, r_b3, r_d3, r_e3;
    logic signed [TW-1:0] r_det3, n_s1, n_s2;
    logic [SW-1:0]        r_s1, r_s2;
    always_comb begin
        n_s1 = TW'(r_paa) + TW'(r_pbb);
        n_s2 = TW'(r_pdd) + TW'(r_pee);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax3  <= r_ax2;
            r_ay3  <= r_ay2;
            r_a3   <= r_a2;
            r_b3   <= r_b2;
            r_d3   <= r_d2;
            r_e3   <= r_e2;
            r_det3 <= TW'(r_pae) - TW'(r_pbd);
            r_s1   <= n_s1[SW-1:0];
            r_s2   <= n_s2[SW-1:0];
        end
    end

    // stage 4: partial products, lengths split at bit 32
    logic signed [CB-1:0]  r_ax4, r_ay4;
    logic signed [TW-1:0]  r_det4;
    logic signed [PLW-1:0] r_x1l, r_x2l, r_y1l, r_y2l;
    logic signed [PHW-1:0] r_x1h, r_x2h, r_y1h, r_y2h;
    logic signed [LW:0]    s1_lo, s2_lo;
    logic signed [SW-LW:0] s1_hi, s2_hi;
    always_comb begin
        s1_lo = $signed({1'b0, r_s1[LW-1:0]});
        s2_lo = $signed({1'b0, r_s2[LW-1:0]});
        s1_hi = $signed({1'b0, r_s1[SW-1:LW]});
        s2_hi = $signed({1'b0, r_s2[SW-1:LW]});
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax4  <= r_ax3;
            r_ay4  <= r_ay3;
            r_det4 <= r_det3;
            r_x1l  <= PLW'(r_e3) * PLW'(s1_lo);
            r_x1h  <= PHW'(r_e3) * PHW'(s1_hi);
            r_x2l  <= PLW'(r_b3) * PLW'(s2_lo);
            r_x2h  <= PHW'(r_b3) * PHW'(s2_hi);
            r_y1l  <= PLW'(r_a3) * PLW'(s2_lo);
            r_y1h  <= PHW'(r_a3) * PHW'(s2_hi);
            r_y2l  <= PLW'(r_d3) * PLW'(s1_lo);
            r_y2h  <= PHW'(r_d3) * PHW'(s1_hi);
        end
    end

    // stage 5: recombine partial products
    logic signed [CB-1:0] r_ax5, r_ay5;
    logic signed [TW-1:0] r_det5;
    logic signed [NW-1:0] r_px1, r_px2, r_py1, r_py2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax5  <= r_ax4;
            r_ay5  <= r_ay4;
            r_det5 <= r_det4;
            r_px1  <= (NW'(r_x1h) <<< LW) + NW'(r_x1l);
            r_px2  <= (NW'(r_x2h) <<< LW) + NW'(r_x2l);
            r_py1  <= (NW'(r_y1h) <<< LW) + NW'(r_y1l);
            r_py2  <= (NW'(r_y2h) <<< LW) + NW'(r_y2l);
        end
    end

    // stage 6: numerators, magnitudes and quotient signs
    logic signed [NW-1:0] n_nx, n_ny, n_anx, n_any;
    logic signed [TW-1:0] n_adet;
    logic signed [CB-1:0] r_ax6, r_ay6;
    logic [NW-2:0]        r_anx, r_any;
    logic [AW-1:0]        r_adet;
    logic                 r_degen6, r_negx6, r_negy6;
    always_comb begin
        n_nx   = r_px1 - r_px2;
        n_ny   = r_py1 - r_py2;
        n_anx  = n_nx[NW-1] ? -n_nx : n_nx;
        n_any  = n_ny[NW-1] ? -n_ny : n_ny;
        n_adet = r_det5[TW-1] ? -r_det5 : r_det5;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax6    <= r_ax5;
            r_ay6    <= r_ay5;
            r_anx    <= n_anx[NW-2:0];
            r_any    <= n_any[NW-2:0];
            r_adet   <= n_adet[AW-1:0];
            r_degen6 <= (r_det5 == '0);
            r_negx6  <= n_nx[NW-1] ^ r_det5[TW-1];
            r_negy6  <= n_ny[NW-1] ^ r_det5[TW-1];
        end
    end

    // stage 7: rounded division operands
    logic signed [CB-1:0] r_ax7, r_ay7;
    logic [VW-1:0]        r_numx, r_numy;
    logic [EW-1:0]        r_den;
    logic                 r_degen7, r_negx7, r_negy7;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax7    <= r_ax6;
            r_ay7    <= r_ay6;
            r_numx   <= (VW'(r_anx) << tcirc_pkg::FRAC_BITS) + VW'(r_adet);
            r_numy   <= (VW'(r_any) << tcirc_pkg::FRAC_BITS) + VW'(r_adet);
            r_den    <= EW'(r_adet) << 1;
            r_degen7 <= r_degen6;
            r_negx7  <= r_negx6;
            r_negy7  <= r_negy6;
        end
    end

    always_comb begin
        o_front.valid = r_v[6];
        o_front.ax    = r_ax7;
        o_front.ay    = r_ay7;
        o_front.degen = r_degen7;
        o_front.neg_x = r_negx7;
        o_front.neg_y = r_negy7;
        o_front.num_x = r_numx;
        o_front.num_y = r_numy;
        o_front.den   = r_den;
    end

endmodule
`default_nettype wire

// ===== rtl/core/tcirc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcirc_div
// Two-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module tcirc_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire tcirc_pkg::t_front i_front,
    output tcirc_pkg::t_quot      o_quot
);
    localparam int VW = tcirc_pkg::DIV_W;
    localparam int EW = tcirc_pkg::DEN_W;

    typedef struct packed {
        logic [EW-1:0] rem;
        logic [VW-1:0] nq;
    } t_dstep;

    function automatic t_dstep div_step(input logic [EW-1:0] rem,
                                        input logic [VW-1:0] nq,
                                        input logic [EW-1:0] den);
        logic [EW:0] t;
        logic [EW:0] diff;
        logic        ge;
        t_dstep      res;
        t        = {rem, nq[VW-1]};
        diff     = t - {1'b0, den};
        ge       = (t >= {1'b0, den});
        res.rem  = ge ? diff[EW-1:0] : t[EW-1:0];
        res.nq   = {nq[VW-2:0], ge};
        return res;
    endfunction

    logic [EW-1:0]      r_remx [VW];
    logic [EW-1:0]      r_remy [VW];
    logic [VW-1:0]      r_nqx  [VW];
    logic [VW-1:0]      r_nqy  [VW];
    tcirc_pkg::t_side   r_side [VW];

    for (genvar k = 0; k < VW; k++) begin : g_stage
        logic [EW-1:0]    remx_in, remy_in;
        logic [VW-1:0]    nqx_in, nqy_in;
        tcirc_pkg::t_side side_in;
        t_dstep           n_x, n_y;

        if (k == 0) begin : g_first
            always_comb begin
                remx_in       = '0;
                remy_in       = '0;
                nqx_in        = i_front.num_x;
                nqy_in        = i_front.num_y;
                side_in.valid = i_front.valid;
                side_in.ax    = i_front.ax;
                side_in.ay    = i_front.ay;
                side_in.degen = i_front.degen;
                side_in.neg_x = i_front.neg_x;
                side_in.neg_y = i_front.neg_y;
                side_in.den   = i_front.den;
            end
        end else begin : g_next
            always_comb begin
                remx_in = r_remx[k-1];
                remy_in = r_remy[k-1];
                nqx_in  = r_nqx[k-1];
                nqy_in  = r_nqy[k-1];
                side_in = r_side[k-1];
            end
        end

        always_comb begin
            n_x = div_step(remx_in, nqx_in, side_in.den);
            n_y = div_step(remy_in, nqy_in, side_in.den);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k].valid <= 1'b0;
            end else if (i_en) begin
                r_side[k].valid <= side_in.valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_remx[k]       <= n_x.rem;
                r_remy[k]       <= n_y.rem;
                r_nqx[k]        <= n_x.nq;
                r_nqy[k]        <= n_y.nq;
                r_side[k].ax    <= side_in.ax;
                r_side[k].ay    <= side_in.ay;
                r_side[k].degen <= side_in.degen;
                r_side[k].neg_x <= side_in.neg_x;
                r_side[k].neg_y <= side_in.neg_y;
                r_side[k].den   <= side_in.den;
            end
        end
    end

    always_comb begin
        o_quot.valid = r_side[VW-1].valid;
        o_quot.ax    = r_side[VW-1].ax;
        o_quot.ay    = r_side[VW-1].ay;
        o_quot.degen = r_side[VW-1].degen;
        o_quot.neg_x = r_side[VW-1].neg_x;
        o_quot.neg_y = r_side[VW-1].neg_y;
        o_quot.q_x   = r_nqx[VW-1];
        o_quot.q_y   = r_nqy[VW-1];
    end

endmodule
`default_nettype wire

// ===== rtl/core/tcirc_post.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcirc_post
// Centre offset, saturation, squared radius and output register.
// ----------------------------------------------------------------------------
module tcirc_post (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire tcirc_pkg::t_quot                 i_quot,
    output logic                                  o_valid,
    output logic signed [tcirc_pkg::OUT_W-1:0]    o_center_x,
    output logic signed [tcirc_pkg::OUT_W-1:0]    o_center_y,
    output logic        [tcirc_pkg::RSQ_W-1:0]    o_radius_sq,
    output logic        [tcirc_pkg::ST_W-1:0]     o_status
);
    localparam int VW = tcirc_pkg::DIV_W;
    localparam int CWL = tcirc_pkg::CW;
    localparam int OW = tcirc_pkg::OUT_W;
    localparam int RW = tcirc_pkg::RSQ_W;
    localparam int LW = tcirc_pkg::LO_W;

    localparam logic signed [CWL-1:0] C_MAX = {{(CWL-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [CWL-1:0] C_MIN = ~C_MAX;

    logic [2:0] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_quot.valid};
        end
    end

    // stage 1: signed offsets added to A
    logic signed [CWL-1:0] n_qx, n_qy, n_axs, n_ays;
    logic signed [CWL-1:0] r_sx, r_sy;
    logic [LW-1:0]         r_mx, r_my;
    logic                  r_big1, r_degen1;
    always_comb begin
        n_qx  = i_quot.neg_x ? -CWL'(i_quot.q_x) : CWL'(i_quot.q_x);
        n_qy  = i_quot.neg_y ? -CWL'(i_quot.q_y) : CWL'(i_quot.q_y);
        n_axs = CWL'(i_quot.ax) <<< tcirc_pkg::FRAC_BITS;
        n_ays = CWL'(i_quot.ay) <<< tcirc_pkg::FRAC_BITS;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx     <= n_axs + n_qx;
            r_sy     <= n_ays + n_qy;
            r_mx     <= i_quot.q_x[LW-1:0];
            r_my     <= i_quot.q_y[LW-1:0];
            r_big1   <= (i_quot.q_x[VW-1:LW] != '0) || (i_quot.q_y[VW-1:LW] != '0);
            r_degen1 <= i_quot.degen;
        end
    end

    // stage 2: clamp centre, square offsets
    logic signed [OW-1:0] r_cx2, r_cy2;
    logic [RW-1:0]        r_sqx, r_sqy;
    logic                 r_satc2, r_big2, r_degen2;
    logic                 hi_x, lo_x, hi_y, lo_y;
    always_comb begin
        hi_x = (r_sx > C_MAX);
        lo_x = (r_sx < C_MIN);
        hi_y = (r_sy > C_MAX);
        lo_y = (r_sy < C_MIN);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx2    <= hi_x ? C_MAX[OW-1:0] : (lo_x ? C_MIN[OW-1:0] : r_sx[OW-1:0]);
            r_cy2    <= hi_y ? C_MAX[OW-1:0] : (lo_y ? C_MIN[OW-1:0] : r_sy[OW-1:0]);
            r_satc2  <= hi_x | lo_x | hi_y | lo_y;
            r_sqx    <= RW'(r_mx) * RW'(r_mx);
            r_sqy    <= RW'(r_my) * RW'(r_my);
            r_big2   <= r_big1;
            r_degen2 <= r_degen1;
        end
    end

    // stage 3: radius sum and output register
    logic [RW:0] n_sum;
    logic        n_rsat;
    always_comb begin
        n_sum  = (RW+1)'(r_sqx) + (RW+1)'(r_sqy);
        n_rsat = r_big2 | n_sum[RW];
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_degen2) begin
                o_center_x  <= '0;
                o_center_y  <= '0;
                o_radius_sq <= '0;
                o_status    <= tcirc_pkg::ST_DEGEN;
            end else begin
                o_center_x  <= r_cx2;
                o_center_y  <= r_cy2;
                o_radius_sq <= n_rsat ? '1 : n_sum[RW-1:0];
                o_status    <= (n_rsat | r_satc2) ? tcirc_pkg::ST_SAT : tcirc_pkg::ST_OK;
            end
        end
    end

    assign o_valid = r_v[2];

endmodule
`default_nettype wire

// ===== rtl/core/triangle_circumcircle.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_circumcircle
// Circumcentre and squared radius of a triangle, fully pipelined.
// ----------------------------------------------------------------------------
// Input stream: one triangle per transaction, vertices A, B, C as signed
// 24-bit integer coordinates. Output stream: centre x/y with 8 fraction bits
// and squared radius with 16 fraction bits; tuser carries the status
// (0 ok, 1 zero determinant with zero outputs, 2 saturated).
// The pipeline has 7 front stages (edges, determinant, numerators),
// 86 divider stages at one quotient bit each and 3 back stages.
// Throughput is one transaction per cycle unless the receiver stalls;
// every stage is clocked by one common enable.
// Reset clears all valid bits; the pipeline comes up empty.
// While the receiver holds tready low with a result waiting, the whole
// pipeline holds and s_axis_tready is low; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module triangle_circumcircle (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // ax, ay, bx, by_coord, cx, cy (24 bits each)
    input  wire logic [143:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // center_x (40), center_y (40), radius_sq (64)
    output logic [143:0]      m_axis_tdata,
    // status (2)
    output logic [1:0]        m_axis_tuser
);
    logic                                      en;
    tcirc_pkg::t_front                         front;
    tcirc_pkg::t_quot                          quot;
    logic signed [tcirc_pkg::OUT_W-1:0]        center_x, center_y;
    logic [tcirc_pkg::RSQ_W-1:0]               radius_sq;

    assign en            = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = en;

    tcirc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .o_front (front)
    );

    tcirc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_front (front),
        .o_quot  (quot)
    );

    tcirc_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_quot      (quot),
        .o_valid     (m_axis_tvalid),
        .o_center_x  (center_x),
        .o_center_y  (center_y),
        .o_radius_sq (radius_sq),
        .o_status    (m_axis_tuser)
    );

    assign m_axis_tdata = {radius_sq, center_y, center_x};

endmodule
`default_nettype wire
